>>> src/ila_pkg.sv
// Shared constants, types and codes for the interval layer assigner.
// No dependencies; imported by the assigner and the free-layer search.
package ila_pkg;

    localparam int CLUSTER_DEPTH = 64;
    localparam int ADDR_W        = $clog2(CLUSTER_DEPTH);
    localparam int CNT_W         = $clog2(CLUSTER_DEPTH + 1);
    localparam int NUM_LAYERS    = CLUSTER_DEPTH + 2;
    localparam int LAYER_W       = $clog2(NUM_LAYERS);
    localparam int MAX_SEQ       = CLUSTER_DEPTH + 1;

    localparam int COORD_W = 31;
    localparam int REG_W   = 16;
    localparam int IDX_W   = 2;

    // begin_kind codes
    localparam logic [1:0] KIND_CONT  = 2'd0;
    localparam logic [1:0] KIND_SEQ   = 2'd1;
    localparam logic [1:0] KIND_TRACK = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_MAX_LAYER    = 2'd0;
    localparam logic [IDX_W-1:0] REG_LAYER_OFFSET = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] m_start;
        logic [COORD_W-1:0] m_end;
        logic [LAYER_W-1:0] m_layer;
    } t_member;

    // outcome of the free-layer search
    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [LAYER_W-1:0] seq_layers;
        logic [LAYER_W-1:0] peak;
    } t_pick;

endpackage

>>> src/interval_layer_assigner.sv
// An input transfer starts a scan of the cluster store through its single read
// port, one member a cycle; the scan is empty for a new sequence, a new track or
// an empty cluster. The result is then registered and held while stalled, and a
// new interval is accepted only once that result has been registered.
// Reset (synchronous, active low) empties the cluster, sets layer counts to 1,
// max_layer to 50 and layer_offset to 0; the store itself is not swept.
module interval_layer_assigner (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ila_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [ila_pkg::REG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_begin_kind,
    input  logic [ila_pkg::COORD_W-1:0]  i_iv_start,
    input  logic [ila_pkg::COORD_W-1:0]  i_iv_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [15:0]                  o_track_layer,
    output logic                         o_visible,
    output logic                         o_cluster_begin,
    output logic [15:0]                  o_peak_layers,
    output logic                         o_overflow
);
    import ila_pkg::*;

    t_state r_state, n_state;

    logic [REG_W-1:0]      r_max_layer;
    logic [REG_W-1:0]      r_layer_offset;
    logic [COORD_W-1:0]    r_s;
    logic [COORD_W-1:0]    r_e;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_idx;
    logic [LAYER_W-1:0]    r_seq;
    logic [LAYER_W-1:0]    r_peak;
    logic [NUM_LAYERS-1:0] r_taken;
    logic                  r_any;
    logic                  r_cmp_vld;
    t_member               r_rd_data;
    t_member               mem [CLUSTER_DEPTH];

    logic                  r_out_valid;
    logic [15:0]           r_track_layer;
    logic                  r_visible;
    logic                  r_cluster_begin;
    logic [15:0]           r_peak_layers;
    logic                  r_overflow;

    logic                  in_xfer;
    logic                  rd_en;
    logic                  fire;
    logic                  hit;
    logic                  full;
    logic                  we;
    logic [ADDR_W-1:0]     wr_addr;
    t_member               wr_data;
    t_pick                 pick;
    logic [LAYER_W-1:0]    layer;
    logic [REG_W-1:0]      lim;
    logic [REG_W:0]        total;
    logic [REG_W-1:0]      peak_ext;

    ila_pick u_pick (
        .i_taken      (r_taken),
        .i_seq_layers (r_seq),
        .i_peak       (r_peak),
        .o_pick       (pick)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_SCAN;
            ST_SCAN:   if (!rd_en && !r_cmp_vld) n_state = ST_FINISH;
            ST_FINISH: if (fire) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready = 1'b0;
        rd_en   = 1'b0;
        fire    = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_ready = 1'b1;
            ST_SCAN:   rd_en   = (r_idx != r_count);
            ST_FINISH: fire    = !r_out_valid || i_ready;
            default:   o_ready = 1'b0;
        endcase
    end

    assign in_xfer = i_valid && o_ready;
    assign hit     = r_cmp_vld && (r_s <= r_rd_data.m_end) && (r_e >= r_rd_data.m_start);

    // store update and result
    assign full     = (r_count >= CNT_W'(CLUSTER_DEPTH));
    assign layer    = r_any ? pick.layer : LAYER_W'(1);
    assign we       = fire && !(r_any && full);
    assign wr_addr  = r_any ? r_count[ADDR_W-1:0] : ADDR_W'(0);
    assign wr_data  = '{m_start: r_s, m_end: r_e, m_layer: layer};
    assign lim      = (r_max_layer == '0) ? REG_W'(1) : r_max_layer;
    assign total    = {1'b0, REG_W'(layer)} + {1'b0, r_layer_offset};
    assign peak_ext = REG_W'(r_any ? pick.peak : r_peak);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_idx[ADDR_W-1:0]];
        end
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_max_layer    <= REG_W'(50);
            r_layer_offset <= '0;
            r_count        <= '0;
            r_idx          <= '0;
            r_seq          <= LAYER_W'(1);
            r_peak         <= LAYER_W'(1);
            r_cmp_vld      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAX_LAYER:    r_max_layer    <= i_cfg_data;
                    REG_LAYER_OFFSET: r_layer_offset <= i_cfg_data;
                    default:          ;
                endcase
            end

            if (in_xfer) begin
                r_idx <= '0;
                if (i_begin_kind != KIND_CONT) begin
                    r_count <= '0;
                    r_seq   <= LAYER_W'(1);
                    // a code above new-sequence acts as new track
                    if (i_begin_kind >= KIND_TRACK) begin
                        r_peak <= LAYER_W'(1);
                    end
                end
            end else if (rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end

            if (fire) begin
                if (r_any) begin
                    r_seq  <= pick.seq_layers;
                    r_peak <= pick.peak;
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end else begin
                    r_count <= CNT_W'(1);
                end
            end

            r_out_valid <= fire || (r_out_valid && !i_ready);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s     <= i_iv_start;
            r_e     <= i_iv_end;
            r_taken <= '0;
            r_any   <= 1'b0;
        end else if (hit) begin
            r_any <= 1'b1;
            for (int j = 0; j < NUM_LAYERS; j++) begin
                if (r_rd_data.m_layer == LAYER_W'(j)) begin
                    r_taken[j] <= 1'b1;
                end
            end
        end

        if (fire) begin
            r_track_layer   <= total[REG_W] ? '1 : total[REG_W-1:0];
            r_visible       <= (total <= {1'b0, lim});
            r_cluster_begin <= !r_any;
            r_peak_layers   <= (peak_ext > lim) ? lim : peak_ext;
            r_overflow      <= r_any && full;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_track_layer   = r_track_layer;
    assign o_visible       = r_visible;
    assign o_cluster_begin = r_cluster_begin;
    assign o_peak_layers   = r_peak_layers;
    assign o_overflow      = r_overflow;

endmodule

>>> src/ila_pick.sv
// Free-layer search: lowest untaken layer in 1..sequence count, or a new one (count + 1, held at MAX_SEQ).
// Depends on ila_pkg.
module ila_pick (
    input  logic [ila_pkg::NUM_LAYERS-1:0] i_taken,
    input  logic [ila_pkg::LAYER_W-1:0]    i_seq_layers,
    input  logic [ila_pkg::LAYER_W-1:0]    i_peak,
    output ila_pkg::t_pick                 o_pick
);
    import ila_pkg::*;

    logic [LAYER_W-1:0] found_layer;
    logic               found;
    logic [LAYER_W-1:0] seq_inc;

    // priority encoder, lowest free layer wins
    always_comb begin
        found       = 1'b0;
        found_layer = LAYER_W'(1);
        for (int i = NUM_LAYERS - 1; i >= 1; i--) begin
            if (!i_taken[i] && (LAYER_W'(i) <= i_seq_layers)) begin
                found       = 1'b1;
                found_layer = LAYER_W'(i);
            end
        end
    end

    assign seq_inc = (i_seq_layers < LAYER_W'(MAX_SEQ)) ? i_seq_layers + LAYER_W'(1)
                                                         : i_seq_layers;

    always_comb begin
        if (found) begin
            o_pick.layer      = found_layer;
            o_pick.seq_layers = i_seq_layers;
            o_pick.peak       = i_peak;
        end else begin
            o_pick.layer      = seq_inc;
            o_pick.seq_layers = seq_inc;
            o_pick.peak       = (seq_inc > i_peak) ? seq_inc : i_peak;
        end
    end

endmodule

>>> src/ila_checker.sv
// Port-level checks for interval_layer_assigner, attached by bind.
// Depends on the top-level port list.
module ila_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [15:0]                  o_track_layer,
    input  logic                         o_visible,
    input  logic                         o_cluster_begin,
    input  logic [15:0]                  o_peak_layers,
    input  logic                         o_overflow
);

    // a transfer in always starts a scan, so the input side closes
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still ready after a transfer");

    // a result only appears once the scan has finished
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while idle");

    // a fresh cluster is always stored, never an overflow
    a_new_cluster_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cluster_begin) |-> !o_overflow)
        else $error("overflow on a new cluster");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_track_layer)
                                   && $stable(o_peak_layers) && $stable(o_visible)))
        else $error("stalled result changed");

endmodule

bind interval_layer_assigner ila_checker u_ila_checker (.*);
